/* design/imh_pkg.sv */
// Package: shared constants, command and status codes for the indexed min-heap.
`timescale 1ns / 1ps
`default_nettype none
package imh_pkg;
  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_BITS_DEF = 32;
  localparam int ID_W = 10;
  localparam int NUM_IDS = 1024;
  localparam int KEY_IN_W = 32;
  localparam int CNT_OUT_W = 11;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;
endpackage
`default_nettype wire

/* design/imh_if.sv */
// Interfaces: command and result channels with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface imh_cmd_if;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  logic [imh_pkg::ID_W-1:0] node_id;
  logic [imh_pkg::KEY_IN_W-1:0] key_value;
  modport source (output valid, cmd, node_id, key_value, input ready);
  modport sink (input valid, cmd, node_id, key_value, output ready);
endinterface

interface imh_res_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [imh_pkg::ID_W-1:0] popped_id;
  logic [imh_pkg::KEY_IN_W-1:0] popped_key;
  logic [imh_pkg::ID_W-1:0] top_id;
  logic [imh_pkg::KEY_IN_W-1:0] top_key;
  logic [imh_pkg::CNT_OUT_W-1:0] count;
  logic empty_res;
  modport source (output valid, status, popped_id, popped_key, top_id, top_key, count,
                  empty_res, input ready);
  modport sink (input valid, status, popped_id, popped_key, top_id, top_key, count,
                empty_res, output ready);
endinterface
`default_nettype wire

/* design/imh_slot_mem.sv */
// Slot memory: heap slots holding id and key, one write and two read ports.
`timescale 1ns / 1ps
`default_nettype none
module imh_slot_mem #(
  parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = imh_pkg::KEY_BITS_DEF,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [AW-1:0] waddr,
  input wire logic [imh_pkg::ID_W-1:0] wid,
  input wire logic [KEY_BITS-1:0] wkey,
  input wire logic [AW-1:0] raddr_a,
  input wire logic [AW-1:0] raddr_b,
  output logic [imh_pkg::ID_W-1:0] rid_a,
  output logic [KEY_BITS-1:0] rkey_a,
  output logic [imh_pkg::ID_W-1:0] rid_b,
  output logic [KEY_BITS-1:0] rkey_b
);
  import imh_pkg::*;
  logic [ID_W+KEY_BITS-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wid, wkey};
    end
    {rid_a, rkey_a} <= mem[raddr_a];
    {rid_b, rkey_b} <= mem[raddr_b];
  end
endmodule
`default_nettype wire

/* design/imh_pos_mem.sv */
// Position memory: heap slot of each id.
`timescale 1ns / 1ps
`default_nettype none
module imh_pos_mem #(
  parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [imh_pkg::ID_W-1:0] waddr,
  input wire logic [AW-1:0] wpos,
  input wire logic [imh_pkg::ID_W-1:0] raddr,
  output logic [AW-1:0] rpos
);
  import imh_pkg::*;
  logic [AW-1:0] mem [NUM_IDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wpos;
    end
    rpos <= mem[raddr];
  end
endmodule
`default_nettype wire

/* design/indexed_min_heap_decrease_key.sv */
// Top level: indexed binary min-heap with push-or-decrease, pop and clear.
//
//  channel  dir  fields
//  in       in   cmd, node_id, key_value
//  out      out  status, popped_id, popped_key, top_id, top_key, count, empty_res
//
// One item at a time. Clear, undefined command and empty pop go straight to the top read;
// a push first looks up the id's slot, and a rejected push ends there; push/decrease then
// moves the entry up level by level, and pop moves the last entry to the root and down.
// Each level costs one slot read and one slot write; the moving entry stays in registers.
// Reset clears the count, state and out.valid only: an id is present when its stored slot
// is below the count and that slot holds the id, so no clearing pass is needed.
// A result waits in the output register; in.ready rises once it is taken.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_decrease_key #(
  parameter int CAPACITY = imh_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = imh_pkg::KEY_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  imh_cmd_if.sink in,
  imh_res_if.source out
);
  import imh_pkg::*;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_CHECK, S_VERIFY, S_UP_RD, S_UP_CMP,
    S_POP_MV, S_DN_RD, S_DN_CMP, S_TOP_RD, S_TOP, S_OUT
  } state_t;

  state_t state;
  logic [1:0] cmd;
  logic [ID_W-1:0] nid;
  logic [KEY_BITS-1:0] key;
  logic [CW-1:0] cnt;
  logic [AW-1:0] pos;
  logic [ID_W-1:0] cur_id;
  logic [KEY_BITS-1:0] cur_key;
  logic [1:0] status;
  logic [ID_W-1:0] pid;
  logic [KEY_BITS-1:0] pkey;
  logic [ID_W-1:0] top_id;
  logic [KEY_IN_W-1:0] top_key;

  logic s_we;
  logic [AW-1:0] s_waddr, s_ra, s_rb;
  logic [ID_W-1:0] s_wid, rid_a, rid_b;
  logic [KEY_BITS-1:0] s_wkey, rkey_a, rkey_b;
  logic p_we;
  logic [ID_W-1:0] p_waddr;
  logic [AW-1:0] p_wpos, rpos;

  imh_slot_mem #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_slot (
    .clk, .we(s_we), .waddr(s_waddr), .wid(s_wid), .wkey(s_wkey),
    .raddr_a(s_ra), .raddr_b(s_rb), .rid_a, .rkey_a, .rid_b, .rkey_b
  );

  imh_pos_mem #(.CAPACITY(CAPACITY)) u_pos (
    .clk, .we(p_we), .waddr(p_waddr), .wpos(p_wpos), .raddr(nid), .rpos
  );

  logic [AW+1:0] lch, rch;
  logic [AW-1:0] parent;
  logic l_ok, r_ok, take_l, take_r;
  assign parent = AW'((pos - AW'(1)) >> 1);
  assign lch = {1'b0, pos, 1'b1};
  assign rch = {1'b0, pos, 1'b0} + (AW+2)'(2);
  assign l_ok = lch < (AW+2)'(cnt);
  assign r_ok = rch < (AW+2)'(cnt);
  assign take_l = l_ok && (rkey_a < cur_key);
  assign take_r = r_ok && (rkey_b < (take_l ? rkey_a : cur_key));

  always_comb begin
    s_ra = pos;
    s_rb = pos;
    case (state)
      S_LOOK: begin
        s_ra = '0;
        s_rb = AW'(cnt - CW'(1));
      end
      S_CHECK: s_ra = rpos;
      S_UP_RD: s_ra = parent;
      S_DN_RD: begin
        s_ra = AW'(lch);
        s_rb = AW'(rch);
      end
      S_TOP_RD: s_ra = '0;
      default: s_ra = pos;
    endcase
  end

  always_comb begin
    s_we = 1'b0;
    s_waddr = pos;
    s_wid = cur_id;
    s_wkey = cur_key;
    p_we = 1'b0;
    p_waddr = cur_id;
    p_wpos = pos;
    case (state)
      S_UP_RD: begin
        if (pos == '0) begin
          s_we = 1'b1;
          p_we = 1'b1;
        end
      end
      S_UP_CMP: begin
        s_we = 1'b1;
        p_we = 1'b1;
        if (!(rkey_a < cur_key)) begin
          s_wid = rid_a;
          s_wkey = rkey_a;
          p_waddr = rid_a;
        end
      end
      S_DN_CMP: begin
        s_we = 1'b1;
        p_we = 1'b1;
        if (take_r) begin
          s_wid = rid_b;
          s_wkey = rkey_b;
          p_waddr = rid_b;
        end else if (take_l) begin
          s_wid = rid_a;
          s_wkey = rkey_a;
          p_waddr = rid_a;
        end
      end
      default: s_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in.valid) begin
            cmd <= in.cmd;
            nid <= in.node_id;
            key <= KEY_BITS'(in.key_value);
            status <= ST_OK;
            pid <= '0;
            pkey <= '0;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          case (cmd)
            CMD_PUSH: state <= S_CHECK;
            CMD_POP: begin
              if (cnt == '0) begin
                status <= ST_EMPTY;
                state <= S_TOP_RD;
              end else begin
                state <= S_POP_MV;
              end
            end
            CMD_CLEAR: begin
              cnt <= '0;
              state <= S_TOP_RD;
            end
            default: state <= S_TOP_RD;
          endcase
        end
        S_CHECK: begin
          pos <= rpos;
          state <= S_VERIFY;
        end
        S_VERIFY: begin
          cur_id <= nid;
          cur_key <= key;
          if ((CW'(pos) < cnt) && (rid_a == nid)) begin
            if (key < rkey_a) begin
              state <= S_UP_RD;
            end else begin
              status <= ST_REJECT;
              state <= S_TOP_RD;
            end
          end else if (cnt >= CW'(CAPACITY)) begin
            status <= ST_REJECT;
            state <= S_TOP_RD;
          end else begin
            pos <= AW'(cnt);
            cnt <= cnt + CW'(1);
            state <= S_UP_RD;
          end
        end
        S_UP_RD: begin
          if (pos == '0) begin
            state <= S_TOP_RD;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (rkey_a < cur_key) begin
            state <= S_TOP_RD;
          end else begin
            pos <= parent;
            state <= S_UP_RD;
          end
        end
        S_POP_MV: begin
          pid <= rid_a;
          pkey <= rkey_a;
          cur_id <= rid_b;
          cur_key <= rkey_b;
          cnt <= cnt - CW'(1);
          pos <= '0;
          if (cnt == CW'(1)) begin
            state <= S_TOP_RD;
          end else begin
            state <= S_DN_RD;
          end
        end
        S_DN_RD: state <= S_DN_CMP;
        S_DN_CMP: begin
          if (take_r) begin
            pos <= AW'(rch);
            state <= S_DN_RD;
          end else if (take_l) begin
            pos <= AW'(lch);
            state <= S_DN_RD;
          end else begin
            state <= S_TOP_RD;
          end
        end
        S_TOP_RD: state <= S_TOP;
        S_TOP: begin
          if (cnt == '0) begin
            top_id <= '0;
            top_key <= '0;
          end else begin
            top_id <= rid_a;
            top_key <= KEY_IN_W'(rkey_a);
          end
          out.valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out.ready) begin
            out.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in.ready = (state == S_IDLE);
  assign out.status = status;
  assign out.popped_id = pid;
  assign out.popped_key = KEY_IN_W'(pkey);
  assign out.top_id = top_id;
  assign out.top_key = top_key;
  assign out.count = CNT_OUT_W'(cnt);
  assign out.empty_res = (cnt == '0);
endmodule
`default_nettype wire

/* verif/indexed_min_heap_decrease_key_test.sv */
// Testbench: directed table and random commands checked against a heap predictor.
`timescale 1ns / 1ps
module indexed_min_heap_decrease_key_test;
  import imh_pkg::*;

  localparam logic [1:0] CMD_UNDEF = 2'd3;
  localparam int N_DIRECTED = 19;
  localparam int N_RANDOM = 1330;

  typedef struct packed {
    logic [1:0] status;
    logic [ID_W-1:0] popped_id;
    logic [KEY_IN_W-1:0] popped_key;
    logic [ID_W-1:0] top_id;
    logic [KEY_IN_W-1:0] top_key;
    logic [CNT_OUT_W-1:0] count;
    logic empty_res;
  } heap_res_t;

  typedef struct {
    logic [1:0] cmd;
    logic [ID_W-1:0] node_id;
    logic [KEY_IN_W-1:0] key_value;
    bit typed;
    heap_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  imh_cmd_if cmd_ch();
  imh_res_if res_ch();

  indexed_min_heap_decrease_key uut (
    .clk(clk),
    .rst(rst),
    .in(cmd_ch.sink),
    .out(res_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [ID_W-1:0] heap_ids [NUM_IDS];
  logic [KEY_IN_W-1:0] heap_keys [NUM_IDS];
  int unsigned slot_of [NUM_IDS];
  bit in_heap [NUM_IDS];
  int unsigned heap_n;

  heap_res_t pending_results [$];
  int errors = 0;
  int accepted_items = 0;
  int checked_results = 0;
  int pops_seen = 0;
  int rejects_seen = 0;
  int max_depth = 0;
  bit hold_request = 1'b0;

  logic cmd_ready_q;
  logic res_valid_q;
  heap_res_t res_q;

  always @(negedge clk) begin
    cmd_ready_q = cmd_ch.ready;
    res_valid_q = res_ch.valid;
    res_q = '{res_ch.status, res_ch.popped_id, res_ch.popped_key, res_ch.top_id,
              res_ch.top_key, res_ch.count, res_ch.empty_res};
  end

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [ID_W-1:0] ta;
    logic [KEY_IN_W-1:0] ka;
    ta = heap_ids[a];
    ka = heap_keys[a];
    heap_ids[a] = heap_ids[b];
    heap_keys[a] = heap_keys[b];
    heap_ids[b] = ta;
    heap_keys[b] = ka;
    slot_of[heap_ids[a]] = a;
    slot_of[heap_ids[b]] = b;
  endfunction

  function automatic void bubble_up(int unsigned p);
    int unsigned up;
    while (p > 0) begin
      up = (p - 1) / 2;
      if (heap_keys[up] < heap_keys[p]) break;
      swap_slots(p, up);
      p = up;
    end
  endfunction

  function automatic void bubble_down(int unsigned p);
    int unsigned l, r, best;
    forever begin
      l = 2 * p + 1;
      r = 2 * p + 2;
      best = p;
      if (l < heap_n && heap_keys[l] < heap_keys[best]) best = l;
      if (r < heap_n && heap_keys[r] < heap_keys[best]) best = r;
      if (best == p) break;
      swap_slots(p, best);
      p = best;
    end
  endfunction

  function automatic heap_res_t heap_apply(logic [1:0] c, logic [ID_W-1:0] id,
                                           logic [KEY_IN_W-1:0] k);
    heap_res_t r;
    int unsigned p;
    r = '0;
    r.status = ST_OK;
    if (c == CMD_PUSH) begin
      if (in_heap[id]) begin
        p = slot_of[id];
        if (p < heap_n && k < heap_keys[p]) begin
          heap_keys[p] = k;
          bubble_up(p);
        end else begin
          r.status = ST_REJECT;
        end
      end else if (heap_n >= CAPACITY_DEF) begin
        r.status = ST_REJECT;
      end else begin
        p = heap_n;
        heap_ids[p] = id;
        heap_keys[p] = k;
        slot_of[id] = p;
        in_heap[id] = 1'b1;
        heap_n++;
        bubble_up(p);
      end
    end else if (c == CMD_POP) begin
      if (heap_n == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.popped_id = heap_ids[0];
        r.popped_key = heap_keys[0];
        swap_slots(0, heap_n - 1);
        heap_n--;
        in_heap[r.popped_id] = 1'b0;
        bubble_down(0);
      end
    end else if (c == CMD_CLEAR) begin
      heap_n = 0;
      foreach (in_heap[i]) in_heap[i] = 1'b0;
    end
    if (heap_n != 0) begin
      r.top_id = heap_ids[0];
      r.top_key = heap_keys[0];
    end
    r.count = CNT_OUT_W'(heap_n);
    r.empty_res = (heap_n == 0);
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic [1:0] c, logic [ID_W-1:0] id, logic [KEY_IN_W-1:0] k,
                           bit typed, heap_res_t typed_res);
    heap_res_t r;
    int gap;
    gap = (accepted_items % 200 < 60) ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd <= c;
    cmd_ch.node_id <= id;
    cmd_ch.key_value <= k;
    @(posedge clk);
    while (!cmd_ready_q) @(posedge clk);
    r = heap_apply(c, id, k);
    if (typed) r = typed_res;
    pending_results = {pending_results, r};
    accepted_items++;
    if (heap_n > max_depth) max_depth = heap_n;
    if (accepted_items == 500) hold_request = 1'b1;
  endtask

  int recv_gap = 0;
  int recv_hold = 0;
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_request && recv_hold == 0) begin
      hold_request = 1'b0;
      recv_hold = 400;
      res_ch.ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold--;
      res_ch.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if (accepted_items % 300 >= 100) recv_gap = pick_gap();
    end
  end

  always @(posedge clk) begin
    heap_res_t e;
    if (!rst && res_valid_q && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $realtime, res_q);
        errors++;
      end else begin
        e = pending_results.pop_front();
        checked_results++;
        if (res_q.status == ST_EMPTY) pops_seen++;
        if (res_q.status == ST_REJECT) rejects_seen++;
        if (res_q.status !== e.status)
          $display("%0t: status expected %0d actual %0d", $realtime, e.status, res_q.status);
        if (res_q.popped_id !== e.popped_id)
          $display("%0t: popped_id expected %0d actual %0d", $realtime, e.popped_id,
                   res_q.popped_id);
        if (res_q.popped_key !== e.popped_key)
          $display("%0t: popped_key expected %h actual %h", $realtime, e.popped_key,
                   res_q.popped_key);
        if (res_q.top_id !== e.top_id)
          $display("%0t: top_id expected %0d actual %0d", $realtime, e.top_id, res_q.top_id);
        if (res_q.top_key !== e.top_key)
          $display("%0t: top_key expected %h actual %h", $realtime, e.top_key, res_q.top_key);
        if (res_q.count !== e.count)
          $display("%0t: count expected %0d actual %0d", $realtime, e.count, res_q.count);
        if (res_q.empty_res !== e.empty_res)
          $display("%0t: empty_res expected %0d actual %0d", $realtime, e.empty_res,
                   res_q.empty_res);
        if (res_q !== e) errors++;
      end
    end
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

  stim_row_t dir_rows [N_DIRECTED];

  initial begin
    int roll;
    logic [1:0] c;
    logic [ID_W-1:0] id;
    logic [KEY_IN_W-1:0] k;
    logic [KEY_IN_W-1:0] old_key;
    cmd_ch.valid = 1'b0;
    cmd_ch.cmd = CMD_PUSH;
    cmd_ch.node_id = '0;
    cmd_ch.key_value = '0;
    res_ch.ready = 1'b0;
    heap_n = 0;
    foreach (in_heap[i]) in_heap[i] = 1'b0;

    dir_rows[0] = '{CMD_POP, 0, 0, 1, '{ST_EMPTY, 0, 0, 0, 0, 0, 1}};
    dir_rows[1] = '{CMD_PUSH, 1023, 32'hFFFFFFFF, 1, '{ST_OK, 0, 0, 1023, 32'hFFFFFFFF, 1, 0}};
    dir_rows[2] = '{CMD_PUSH, 1023, 32'hFFFFFFFF, 1,
                    '{ST_REJECT, 0, 0, 1023, 32'hFFFFFFFF, 1, 0}};
    dir_rows[3] = '{CMD_PUSH, 0, 0, 1, '{ST_OK, 0, 0, 0, 0, 2, 0}};
    dir_rows[4] = '{CMD_PUSH, 682, 0, 1, '{ST_OK, 0, 0, 682, 0, 3, 0}};
    dir_rows[5] = '{CMD_PUSH, 341, 32'h5555AAAA, 0, '0};
    dir_rows[6] = '{CMD_PUSH, 1023, 32'h00000001, 0, '0};
    dir_rows[7] = '{CMD_PUSH, 0, 0, 1, '{ST_REJECT, 0, 0, 682, 0, 4, 0}};
    dir_rows[8] = '{CMD_UNDEF, 7, 123, 0, '0};
    dir_rows[9] = '{CMD_POP, 0, 0, 0, '0};
    dir_rows[10] = '{CMD_POP, 0, 0, 0, '0};
    dir_rows[11] = '{CMD_POP, 0, 0, 0, '0};
    dir_rows[12] = '{CMD_POP, 0, 0, 0, '0};
    dir_rows[13] = '{CMD_POP, 0, 0, 1, '{ST_EMPTY, 0, 0, 0, 0, 0, 1}};
    dir_rows[14] = '{CMD_PUSH, 512, 32'hAAAA5555, 0, '0};
    dir_rows[15] = '{CMD_PUSH, 256, 32'h80000000, 0, '0};
    dir_rows[16] = '{CMD_CLEAR, 0, 0, 1, '{ST_OK, 0, 0, 0, 0, 0, 1}};
    dir_rows[17] = '{CMD_PUSH, 512, 7, 1, '{ST_OK, 0, 0, 512, 7, 1, 0}};
    dir_rows[18] = '{CMD_POP, 0, 0, 1, '{ST_OK, 512, 7, 0, 0, 0, 1}};

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].cmd, dir_rows[i].node_id, dir_rows[i].key_value,
                dir_rows[i].typed, dir_rows[i].res);

    for (int n = 0; n < N_RANDOM; n++) begin
      roll = $urandom_range(0, 999);
      id = ID_W'($urandom_range(0, NUM_IDS - 1));
      case ($urandom_range(0, 3))
        0: k = $urandom();
        1: k = $urandom_range(0, 15);
        2: k = $urandom_range(0, 255) << 16;
        default: k = $urandom_range(0, 1) ? 32'hFFFFFFFF : $urandom_range(0, 3);
      endcase
      if (roll < 600) begin
        c = CMD_PUSH;
        if (heap_n > 0 && roll < 250) begin
          id = heap_ids[$urandom_range(0, heap_n - 1)];
          old_key = heap_keys[slot_of[id]];
          if (roll < 200 && old_key != 0) k = $urandom_range(0, old_key - 1);
        end
      end else if (roll < 960) begin
        c = CMD_POP;
      end else if (roll < 975) begin
        c = CMD_CLEAR;
      end else begin
        c = CMD_UNDEF;
      end
      send_item(c, id, k, 0, '0);
    end
    cmd_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Ran %0d items (%0d results checked); peak heap depth %0d,", accepted_items,
             checked_results, max_depth);
    $display("%0d empty pops, %0d rejected pushes, with a long output stall.", pops_seen,
             rejects_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
